[rtl/pip_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

	localparam int SEEN_W = 2;
	localparam logic [SEEN_W-1:0] SEEN_ONE = 2'd1;
	localparam logic [SEEN_W-1:0] SEEN_MAX = 2'd3;
	localparam logic [SEEN_W-1:0] MIN_VERTICES = 2'd3;

	typedef struct packed {
		logic first;
		logic last;
		logic degen;
	} pip_ctl_t;

endpackage

`default_nettype wire

[rtl/pip_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pip_in_if #(
	parameter int COORD_BITS = 24
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic first_vertex;
	logic last_vertex;

	modport source (
		output valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
		input ready
	);
	modport sink (
		input valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
		output ready
	);
endinterface

`default_nettype wire

[rtl/pip_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pip_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic degenerate;

	modport source (
		output valid, inside_res, degenerate,
		input ready
	);
	modport sink (
		input valid, inside_res, degenerate,
		output ready
	);
endinterface

`default_nettype wire

[rtl/pip_edge_prod.sv]
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_prod #(
	parameter int COORD_BITS = 24
) (
	input  wire logic signed [COORD_BITS-1:0]     xi,
	input  wire logic signed [COORD_BITS-1:0]     yi,
	input  wire logic signed [COORD_BITS-1:0]     xj,
	input  wire logic signed [COORD_BITS-1:0]     yj,
	input  wire logic signed [COORD_BITS-1:0]     qx,
	input  wire logic signed [COORD_BITS-1:0]     qy,
	output logic                                  straddle,
	output logic signed [2*(COORD_BITS+1)-1:0]    lhs,
	output logic signed [2*(COORD_BITS+1)-1:0]    rhs
);

	localparam int D = COORD_BITS + 1;
	localparam int P = 2 * D;

	logic signed [D-1:0] dx;
	logic signed [D-1:0] dy;
	logic signed [D-1:0] dxp;
	logic signed [D-1:0] dyp;
	logic signed [D-1:0] ex;
	logic signed [D-1:0] ey;

	always_comb begin
		straddle = (yi > qy) != (yj > qy);
		dx = D'(xj) - D'(xi);
		dy = D'(yj) - D'(yi);
		// take the sign of dy out so the inequality keeps its direction
		if (dy < 0) begin
			dxp = -dx;
			dyp = -dy;
		end else begin
			dxp = dx;
			dyp = dy;
		end
		ex = D'(qx) - D'(xi);
		ey = D'(qy) - D'(yi);
		lhs = P'(ex) * P'(dyp);
		rhs = P'(dxp) * P'(ey);
	end

endmodule

`default_nettype wire

[rtl/point_in_polygon_test_core.sv]
// result: the last vertex passes the stage one, stage two and result registers before result.valid rises
// throughput: one vertex per cycle unless a held result stalls the pipeline, no gaps between polygons
// stage one holds the two cross-multiply units per edge and stage two
// holds the signed compare, each a single registered step
// reset: asynchronous, clears pipeline valids, parity, vertex count and held points to zero
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_core #(
	parameter int COORD_BITS = 24
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pip_in_if.sink      vertex,
	pip_out_if.source   result
);

	localparam int P = 2 * (COORD_BITS + 1);

	logic signed [COORD_BITS-1:0] hqx_q, hqy_q;
	logic signed [COORD_BITS-1:0] start_x_q, start_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [pip_pkg::SEEN_W-1:0]   seen_q;
	logic                         parity_q;

	logic signed [COORD_BITS-1:0] eff_qx, eff_qy, eff_sx, eff_sy;
	logic [pip_pkg::SEEN_W-1:0]   seen_nxt;
	logic                         in_tr;

	logic                         s1_valid;
	pip_pkg::pip_ctl_t            s1_ctl;
	logic signed [COORD_BITS-1:0] qx_s1, qy_s1, vx_s1, vy_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, sx_s1, sy_s1;

	logic                         a_st, b_st;
	logic signed [P-1:0]          a_l, a_r, b_l, b_r;

	logic                         s2_valid;
	pip_pkg::pip_ctl_t            s2_ctl;
	logic                         a_st_s2, b_st_s2;
	logic signed [P-1:0]          a_l_s2, a_r_s2, b_l_s2, b_r_s2;

	logic out_valid_q, out_inside_q, out_degen_q;
	logic out_free, s2_go, s2_load, s1_go, s1_load;
	logic flip_a, flip_b, par_run, par_out;

	// flow control
	always_comb begin
		out_free = !out_valid_q || result.ready;
		s2_go = s2_valid && (!s2_ctl.last || out_free);
		s2_load = !s2_valid || s2_go;
		s1_go = s1_valid && s2_load;
		s1_load = !s1_valid || s1_go;
	end

	assign vertex.ready = s1_load;
	assign in_tr = vertex.valid && vertex.ready;

	always_comb begin
		eff_qx = vertex.first_vertex ? vertex.query_x : hqx_q;
		eff_qy = vertex.first_vertex ? vertex.query_y : hqy_q;
		eff_sx = vertex.first_vertex ? vertex.vertex_x : start_x_q;
		eff_sy = vertex.first_vertex ? vertex.vertex_y : start_y_q;
		if (vertex.first_vertex) begin
			seen_nxt = pip_pkg::SEEN_ONE;
		end else if (seen_q == pip_pkg::SEEN_MAX) begin
			seen_nxt = seen_q;
		end else begin
			seen_nxt = seen_q + pip_pkg::SEEN_ONE;
		end
	end

	// polygon state, updated in transaction order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hqx_q <= '0;
			hqy_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			seen_q <= '0;
		end else if (in_tr) begin
			hqx_q <= eff_qx;
			hqy_q <= eff_qy;
			start_x_q <= eff_sx;
			start_y_q <= eff_sy;
			prev_x_q <= vertex.vertex_x;
			prev_y_q <= vertex.vertex_y;
			seen_q <= seen_nxt;
		end
	end

	// stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_load) begin
			s1_valid <= vertex.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_tr) begin
			s1_ctl.first <= vertex.first_vertex;
			s1_ctl.last <= vertex.last_vertex;
			s1_ctl.degen <= seen_nxt < pip_pkg::MIN_VERTICES;
			qx_s1 <= eff_qx;
			qy_s1 <= eff_qy;
			vx_s1 <= vertex.vertex_x;
			vy_s1 <= vertex.vertex_y;
			px_s1 <= prev_x_q;
			py_s1 <= prev_y_q;
			sx_s1 <= eff_sx;
			sy_s1 <= eff_sy;
		end
	end

	// edge from the previous vertex to this one
	pip_edge_prod #(
		.COORD_BITS(COORD_BITS)
	) u_edge_prev (
		.xi(vx_s1), .yi(vy_s1), .xj(px_s1), .yj(py_s1),
		.qx(qx_s1), .qy(qy_s1),
		.straddle(a_st), .lhs(a_l), .rhs(a_r)
	);

	// closing edge from this vertex back to the first
	pip_edge_prod #(
		.COORD_BITS(COORD_BITS)
	) u_edge_close (
		.xi(sx_s1), .yi(sy_s1), .xj(vx_s1), .yj(vy_s1),
		.qx(qx_s1), .qy(qy_s1),
		.straddle(b_st), .lhs(b_l), .rhs(b_r)
	);

	// stage two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_load) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			s2_ctl <= s1_ctl;
			a_st_s2 <= a_st;
			b_st_s2 <= b_st;
			a_l_s2 <= a_l;
			a_r_s2 <= a_r;
			b_l_s2 <= b_l;
			b_r_s2 <= b_r;
		end
	end

	always_comb begin
		flip_a = a_st_s2 && !s2_ctl.first && (a_l_s2 < a_r_s2);
		flip_b = b_st_s2 && (b_l_s2 < b_r_s2);
		par_run = s2_ctl.first ? 1'b0 : (parity_q ^ flip_a);
		par_out = par_run ^ flip_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (s2_go) begin
			parity_q <= par_run;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go && s2_ctl.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && s2_ctl.last) begin
			out_inside_q <= par_out && !s2_ctl.degen;
			out_degen_q <= s2_ctl.degen;
		end
	end

	assign result.valid = out_valid_q;
	assign result.inside_res = out_inside_q;
	assign result.degenerate = out_degen_q;

	a_inside_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.inside_res && result.degenerate))
		else $error("inside reported for degenerate polygon");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vertex.ready |-> (s1_valid && s2_valid && out_valid_q))
		else $error("input stalled with room in the pipeline");

	a_count_after_tr: assert property (@(posedge clk) disable iff (!arst_n)
		in_tr |=> (seen_q != '0))
		else $error("vertex count zero after a transaction");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q)) |-> $past(s2_valid && s2_ctl.last))
		else $error("result without a last vertex");

endmodule

`default_nettype wire
